[design/tga_rle_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the TGA truecolor RLE decoder.
// No dependencies; used by the channel interfaces and the core.
package tga_rle_pkg;

    // Largest image side; the pixel count in use is clamped to its square
    localparam int unsigned MAX_SIDE    = 1024;
    localparam int unsigned PIXEL_LIMIT = MAX_SIDE * MAX_SIDE;

    // Field widths
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned PIX_W    = 32;
    localparam int unsigned REP_W    = 8;
    localparam int unsigned INDEX_W  = 20;
    localparam int unsigned COUNT_W  = 21;
    localparam int unsigned ERR_W    = 2;
    localparam int unsigned BPP_W    = 3;
    localparam int unsigned PADDR_W  = 4;
    localparam int unsigned PDATA_W  = 32;

    // Packet header layout and alpha fill
    localparam logic [6:0]        RUN_MASK     = 7'h7f;
    localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hff;
    localparam logic [BPP_W-1:0]  BPP_BGRA     = 3'd4;

    // Configuration register indexes (byte address / 4)
    localparam logic [1:0] CFG_RLE_MODE    = 2'd0;
    localparam logic [1:0] CFG_BPP         = 2'd1;
    localparam logic [1:0] CFG_PIXEL_COUNT = 2'd2;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE      = 2'd0,
        ERR_OVERRUN   = 2'd1,
        ERR_EARLY_END = 2'd2
    } t_err;

    // One result beat
    typedef struct packed {
        logic [PIX_W-1:0]   pixel_abgr;
        logic [REP_W-1:0]   repeat_count;
        logic [INDEX_W-1:0] start_index;
        logic               image_done;
        t_err               error_code;
    } t_pix_result;

endpackage

[design/tga_rle_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces: byte stream in, decoded pixels out.
// Depends on tga_rle_pkg for field widths.
interface tga_rle_byte_if import tga_rle_pkg::*; ;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_data;

    modport source (output valid, data_byte, end_of_data, input ready);
    modport sink   (input valid, data_byte, end_of_data, output ready);
endinterface

interface tga_rle_pix_if import tga_rle_pkg::*; ;
    logic               valid;
    logic               ready;
    logic [PIX_W-1:0]   pixel_abgr;
    logic [REP_W-1:0]   repeat_count;
    logic [INDEX_W-1:0] start_index;
    logic               image_done;
    logic [ERR_W-1:0]   error_code;

    modport source (output valid, pixel_abgr, repeat_count, start_index, image_done,
                    error_code, input ready);
    modport sink   (input valid, pixel_abgr, repeat_count, start_index, image_done,
                    error_code, output ready);
endinterface

[design/tga_truecolor_rle_decoder_core.sv]
`timescale 1ns / 1ps
// TGA truecolor (raw / RLE) pixel stream decoder, single-pass per byte.
// Depends on tga_rle_pkg and the channel interfaces in tga_rle_if.sv.
//
//  channel    | dir | handshake       | beat contents
//  -----------+-----+-----------------+-------------------------------------------
//  i_byte_ch  | in  | valid / ready   | data_byte, end_of_data
//  o_pix_ch   | out | valid / ready   | pixel_abgr, repeat_count, start_index,
//             |     |                 | image_done, error_code
//  APB        | in  | psel / penable  | rle_mode @0x0, bytes_per_pixel @0x4,
//             |     |                 | pixel_count @0x8
//
// One byte is taken every clock while ready is high; any result is registered.
// The per-byte decode is one shallow compare/add stage into the result register.
// A two-deep output (result register plus skid) keeps input flowing for one
// stalled result; i_byte_ch.ready drops only while both entries are full.
// Synchronous active-low reset clears decode state and restores the registers.
// After image completion or an error, bytes are still taken but dropped.
module tga_truecolor_rle_decoder_core import tga_rle_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    tga_rle_byte_if.sink       i_byte_ch,
    tga_rle_pix_if.source      o_pix_ch,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    // Configuration registers
    logic               r_rle_mode;
    logic [BPP_W-1:0]   r_bpp;
    logic [COUNT_W-1:0] r_pixel_count;

    // Decode state
    logic               r_expect_hdr,  n_expect_hdr;
    logic               r_run_repeat,  n_run_repeat;
    logic [REP_W-1:0]   r_left,        n_left;
    logic [1:0]         r_bip,         n_bip;
    logic [23:0]        r_partial,     n_partial;
    logic [COUNT_W-1:0] r_pd,          n_pd;
    logic               r_stopped,     n_stopped;

    // Output register and skid entry
    logic        r_out_valid, r_skid_valid;
    t_pix_result r_out, r_skid;

    logic               w_cfg_wr;
    logic               w_in_fire;
    logic               w_pop;
    logic               w_push;
    logic               w_emit;
    t_pix_result        w_res;
    logic [COUNT_W-1:0] w_total;
    logic [REP_W-1:0]   w_run;
    logic [COUNT_W:0]   w_hdr_sum;
    logic               w_bgra;
    logic [1:0]         w_last_pos;
    logic [1:0]         w_pos;
    logic [23:0]        w_part;
    logic [REP_W-1:0]   w_pkt_left;
    logic [REP_W-1:0]   w_rep;

    // APB register port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rle_mode    <= 1'b0;
            r_bpp         <= BPP_BGRA;
            r_pixel_count <= COUNT_W'(1);
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                CFG_RLE_MODE:    r_rle_mode    <= pwdata[0];
                CFG_BPP:         r_bpp         <= pwdata[BPP_W-1:0];
                CFG_PIXEL_COUNT: r_pixel_count <= pwdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            CFG_RLE_MODE:    prdata = PDATA_W'(r_rle_mode);
            CFG_BPP:         prdata = PDATA_W'(r_bpp);
            CFG_PIXEL_COUNT: prdata = PDATA_W'(r_pixel_count);
            default:         prdata = '0;
        endcase
    end

    // Clamped image size
    always_comb begin
        if (r_pixel_count == '0) begin
            w_total = COUNT_W'(1);
        end else if (32'(r_pixel_count) > PIXEL_LIMIT) begin
            w_total = COUNT_W'(PIXEL_LIMIT);
        end else begin
            w_total = r_pixel_count;
        end
    end

    // Handshakes
    assign i_byte_ch.ready = !r_skid_valid;
    assign w_in_fire       = i_byte_ch.valid && !r_skid_valid && !r_stopped;
    assign w_pop           = r_out_valid && o_pix_ch.ready;
    assign w_push          = w_in_fire && w_emit;

    // Packet header arithmetic
    assign w_run     = {1'b0, i_byte_ch.data_byte[6:0] & RUN_MASK} + REP_W'(1);
    assign w_hdr_sum = {1'b0, r_pd} + (COUNT_W+1)'(w_run);

    // Byte position within the pixel, clamped to the last byte
    assign w_bgra     = (r_bpp == BPP_BGRA);
    assign w_last_pos = w_bgra ? 2'd3 : 2'd2;
    assign w_pos      = (r_bip > w_last_pos) ? w_last_pos : r_bip;
    assign w_pkt_left = (r_left == '0) ? REP_W'(1) : r_left;
    assign w_rep      = (r_rle_mode && r_run_repeat) ? w_pkt_left : REP_W'(1);

    // Colour byte merge (B, G, R lanes)
    always_comb begin
        w_part = r_partial;
        case (w_pos)
            2'd0:    w_part[7:0]   = i_byte_ch.data_byte;
            2'd1:    w_part[15:8]  = i_byte_ch.data_byte;
            2'd2:    w_part[23:16] = i_byte_ch.data_byte;
            default: ;
        endcase
    end

    // Per-byte decode
    always_comb begin
        n_expect_hdr = r_expect_hdr;
        n_run_repeat = r_run_repeat;
        n_left       = r_left;
        n_bip        = r_bip;
        n_partial    = r_partial;
        n_pd         = r_pd;
        n_stopped    = r_stopped;
        w_emit       = 1'b0;
        w_res        = '0;
        w_res.error_code = ERR_NONE;

        if (w_in_fire) begin
            if (r_rle_mode && r_expect_hdr) begin
                if (w_hdr_sum > {1'b0, w_total}) begin
                    w_res.error_code  = ERR_OVERRUN;
                    w_res.start_index = r_pd[INDEX_W-1:0];
                    n_stopped         = 1'b1;
                    w_emit            = 1'b1;
                end else begin
                    n_run_repeat = i_byte_ch.data_byte[7];
                    n_left       = w_run;
                    n_expect_hdr = 1'b0;
                end
            end else if (w_pos != w_last_pos) begin
                n_partial = w_part;
                n_bip     = w_pos + 2'd1;
            end else begin
                // Pixel complete
                w_res.pixel_abgr   = {w_bgra ? i_byte_ch.data_byte : ALPHA_OPAQUE,
                                      w_part[7:0], w_part[15:8], w_part[23:16]};
                w_res.repeat_count = w_rep;
                w_res.start_index  = r_pd[INDEX_W-1:0];
                n_bip              = 2'd0;
                n_partial          = '0;
                n_pd               = r_pd + COUNT_W'(w_rep);
                if (r_rle_mode) begin
                    if (r_run_repeat) begin
                        n_left = '0;
                    end else begin
                        n_left = w_pkt_left - REP_W'(1);
                    end
                    if (n_left == '0) begin
                        n_expect_hdr = 1'b1;
                    end
                end
                w_emit = 1'b1;
                if (n_pd >= w_total) begin
                    w_res.image_done = 1'b1;
                    n_stopped        = 1'b1;
                end
            end

            // Data ran out before the image was complete
            if (i_byte_ch.end_of_data && !n_stopped) begin
                w_res.error_code = ERR_EARLY_END;
                n_stopped        = 1'b1;
                if (!w_emit) begin
                    w_res.start_index = n_pd[INDEX_W-1:0];
                    w_emit            = 1'b1;
                end
            end
        end
    end

    // Decode state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_hdr <= 1'b1;
            r_run_repeat <= 1'b0;
            r_left       <= '0;
            r_bip        <= '0;
            r_partial    <= '0;
            r_pd         <= '0;
            r_stopped    <= 1'b0;
        end else begin
            r_expect_hdr <= n_expect_hdr;
            r_run_repeat <= n_run_repeat;
            r_left       <= n_left;
            r_bip        <= n_bip;
            r_partial    <= n_partial;
            r_pd         <= n_pd;
            r_stopped    <= n_stopped;
        end
    end

    // Output register / skid control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_push) begin
            if (r_out_valid && !w_pop) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (w_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_pop) begin
                r_out <= r_skid;
            end
        end else if (w_push) begin
            if (r_out_valid && !w_pop) begin
                r_skid <= w_res;
            end else begin
                r_out <= w_res;
            end
        end
    end

    assign o_pix_ch.valid        = r_out_valid;
    assign o_pix_ch.pixel_abgr   = r_out.pixel_abgr;
    assign o_pix_ch.repeat_count = r_out.repeat_count;
    assign o_pix_ch.start_index  = r_out.start_index;
    assign o_pix_ch.image_done   = r_out.image_done;
    assign o_pix_ch.error_code   = r_out.error_code;

`ifndef SYNTHESIS
    // Skid entry is only ever filled behind a held result
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid without output register valid");

    // A final result (done or error) leaves the decoder stopped
    a_final_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push && (w_res.image_done || w_res.error_code != ERR_NONE) |=> r_stopped)
        else $error("decoder not stopped after final result");

    // Nothing is produced once stopped
    a_no_result_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |-> !w_push)
        else $error("result produced while stopped");

    // A full output stage frees only through a taken result
    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && !o_pix_ch.ready |=> r_skid_valid && $stable(r_out))
        else $error("stalled output stage changed");
`endif

endmodule

[verif/tga_truecolor_rle_decoder_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for the TGA truecolor raw/RLE pixel decoder core.
// Needs tga_rle_pkg, the channel interfaces and the core; a scoreboard class
// predicts every pixel beat, plain tasks drive the byte and APB ports, and a process drives pixel ready.

import tga_rle_pkg::*;

// Predicts the decoder's pixel beats and checks the ones the core delivers
class tga_pixel_scoreboard;
    localparam int unsigned MAX_REPORTS = 60;

    // register copies
    bit           rle_on;
    logic [2:0]   bpp_reg;
    logic [20:0]  count_reg;
    // decode state
    bit           want_header;
    bit           run_repeats;
    logic [7:0]   run_left;
    logic [1:0]   byte_pos;
    logic [23:0]  partial;
    logic [20:0]  done_pixels;
    bit           halted;
    t_pix_result  pending_pixels[$];
    int unsigned  mismatches;

    function new();
        mismatches = 0;
        restart();
    endfunction

    function void restart();
        rle_on      = 1'b0;
        bpp_reg     = BPP_BGRA;
        count_reg   = 21'd1;
        want_header = 1'b1;
        run_repeats = 1'b0;
        run_left    = '0;
        byte_pos    = '0;
        partial     = '0;
        done_pixels = '0;
        halted      = 1'b0;
        pending_pixels.delete();
    endfunction

    function void set_reg(input logic [1:0] idx, input logic [31:0] value);
        case (idx)
            CFG_RLE_MODE:    rle_on    = value[0];
            CFG_BPP:         bpp_reg   = value[BPP_W-1:0];
            CFG_PIXEL_COUNT: count_reg = value[COUNT_W-1:0];
            default: ;
        endcase
    endfunction

    // Pixel count as the core uses it: clamped to 1 .. MAX_SIDE^2
    function int unsigned image_size();
        int unsigned total;
        total = count_reg;
        if (total < 1) total = 1;
        if (total > PIXEL_LIMIT) total = PIXEL_LIMIT;
        return total;
    endfunction

    function int unsigned pixel_bytes();
        return (bpp_reg == BPP_BGRA) ? 4 : 3;
    endfunction

    // True at a pixel start, which in RLE mode must also be a packet start
    function bit at_boundary();
        return (byte_pos == 0) && (!rle_on || want_header);
    endfunction

    function int unsigned outstanding();
        return pending_pixels.size();
    endfunction

    function int unsigned b7(input logic [7:0] value);
        return value[6:0];
    endfunction

    // Decode one accepted byte beat; queue the pixel beat it causes, if any
    function void note_byte(input logic [7:0] value, input logic last);
        int unsigned total, run, pos, nb, left, rep, start;
        logic [7:0]  alpha;
        logic [31:0] px;
        bit          emit, finished;
        t_err        err;
        t_pix_result res;

        if (halted) return;
        total    = image_size();
        px       = '0;
        rep      = 0;
        start    = 0;
        emit     = 1'b0;
        finished = 1'b0;
        err      = ERR_NONE;

        if (rle_on && want_header) begin
            // packet header: overrun is checked ahead of end of data
            run = b7(value) + 1;
            if (done_pixels + run > total) begin
                err    = ERR_OVERRUN;
                start  = done_pixels;
                halted = 1'b1;
                emit   = 1'b1;
            end else begin
                run_repeats = value[7];
                run_left    = run[7:0];
                want_header = 1'b0;
            end
        end else begin
            // pixel byte; a position past the pixel size counts as its last byte
            nb  = pixel_bytes();
            pos = byte_pos;
            if (pos >= nb) pos = nb - 1;
            if (pos < 3) partial[8*pos +: 8] = value;
            if (pos + 1 < nb) begin
                byte_pos = 2'(pos + 1);
            end else begin
                alpha    = (nb == 4) ? value : ALPHA_OPAQUE;
                px       = {alpha, partial[7:0], partial[15:8], partial[23:16]};
                byte_pos = '0;
                partial  = '0;
                start    = done_pixels;
                if (!rle_on) begin
                    rep = 1;
                    done_pixels += 1;
                end else begin
                    // empty packet taken as one pixel
                    left = (run_left != 0) ? run_left : 1;
                    if (run_repeats) begin
                        rep = left;
                        done_pixels += left;
                        left = 0;
                    end else begin
                        rep = 1;
                        done_pixels += 1;
                        left -= 1;
                    end
                    run_left = left[7:0];
                    if (left == 0) want_header = 1'b1;
                end
                emit = 1'b1;
                if (done_pixels >= total) begin
                    finished = 1'b1;
                    halted   = 1'b1;
                end
            end
        end

        // data ran out before the image was complete
        if (last && !halted) begin
            err    = ERR_EARLY_END;
            halted = 1'b1;
            if (!emit) begin
                start = done_pixels;
                emit  = 1'b1;
            end
        end

        if (!emit) return;
        res.pixel_abgr   = px;
        res.repeat_count = rep[REP_W-1:0];
        res.start_index  = start[INDEX_W-1:0];
        res.image_done   = finished;
        res.error_code   = err;
        pending_pixels   = {pending_pixels, res};
    endfunction

    task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t ns  %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    // Compare one delivered pixel beat with the oldest prediction
    task check_pixel(input t_pix_result got);
        t_pix_result want;
        if (pending_pixels.size() == 0) begin
            report_mismatch("pixel beat with nothing expected", got.pixel_abgr, 0);
            return;
        end
        want = pending_pixels.pop_front();
        if (got.pixel_abgr !== want.pixel_abgr)
            report_mismatch("pixel_abgr", got.pixel_abgr, want.pixel_abgr);
        if (got.repeat_count !== want.repeat_count)
            report_mismatch("repeat_count", got.repeat_count, want.repeat_count);
        if (got.start_index !== want.start_index)
            report_mismatch("start_index", got.start_index, want.start_index);
        if (got.image_done !== want.image_done)
            report_mismatch("image_done", got.image_done, want.image_done);
        if (got.error_code !== want.error_code)
            report_mismatch("error_code", got.error_code, want.error_code);
    endtask
endclass

module tga_truecolor_rle_decoder_core_tb;

    localparam int unsigned CLK_HALF      = 5;
    localparam int unsigned RESET_CYCLES  = 12;
    localparam int unsigned RANDOM_ITEMS  = 1250;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned RUN_LIMIT_NS  = 10_000_000;

    // how the image is brought to an end; only one per run, as the core stops
    typedef enum int unsigned {
        END_SHORT_PIXEL,
        END_MID_PIXEL,
        END_IMAGE_DONE,
        END_OVERRUN
    } t_ending;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    tga_rle_byte_if byte_ch ();
    tga_rle_pix_if  pix_ch ();

    tga_pixel_scoreboard scoreboard;
    t_pix_result         seen_beat;
    bit                  calm;
    int unsigned         bytes_sent;
    int unsigned         stall_left;

    tga_truecolor_rle_decoder_core dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte_ch (byte_ch),
        .o_pix_ch  (pix_ch),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Gap length: mostly none, some short, a few long; none in calm stretches
    function automatic int unsigned gap_cycles();
        int unsigned roll;
        if (calm) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // Sample both channels at the rising edge: check results, then log input beats
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (pix_ch.valid === 1'b1 && pix_ch.ready === 1'b1) begin
                seen_beat.pixel_abgr   = pix_ch.pixel_abgr;
                seen_beat.repeat_count = pix_ch.repeat_count;
                seen_beat.start_index  = pix_ch.start_index;
                seen_beat.image_done   = pix_ch.image_done;
                seen_beat.error_code   = t_err'(pix_ch.error_code);
                scoreboard.check_pixel(seen_beat);
            end
            if (byte_ch.valid === 1'b1 && byte_ch.ready === 1'b1)
                scoreboard.note_byte(byte_ch.data_byte, byte_ch.end_of_data);
        end
    end

    // Pixel sink: random stalls of random length
    initial begin
        pix_ch.ready = 1'b0;
        stall_left   = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left == 0 && !calm && $urandom_range(0, 99) < 18)
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                         : $urandom_range(1, 3);
            if (stall_left != 0) begin
                pix_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                pix_ch.ready <= 1'b1;
            end
        end
    end

    // APB write: setup then access, then psel drops before it returns
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        scoreboard.set_reg(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    // One byte beat, after a random gap; called and returns at a falling edge
    task automatic send_byte(input logic [7:0] value, input logic last);
        int unsigned gap;
        gap = gap_cycles();
        if (gap != 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        byte_ch.valid       <= 1'b1;
        byte_ch.data_byte   <= value;
        byte_ch.end_of_data <= last;
        do @(posedge i_clk); while (byte_ch.ready !== 1'b1);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_random_bytes(input int unsigned count);
        repeat (count) send_byte(rand_byte(), 1'b0);
    endtask

    // Finish any partial pixel or packet left over from earlier settings
    task automatic realign();
        while (!scoreboard.at_boundary()) send_byte(rand_byte(), 1'b0);
    endtask

    // Sender pauses until every predicted pixel has come out
    task automatic wait_for_results();
        byte_ch.valid <= 1'b0;
        while (scoreboard.outstanding() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        #(RUN_LIMIT_NS);
        $display("tga_truecolor_rle_decoder_core_tb: done, errors");
        $finish;
    end

    initial begin
        int unsigned nb, first_random, need, spare, low7;
        logic [7:0]  header;
        t_ending     ending;

        i_rst_n             = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        byte_ch.valid       = 1'b0;
        byte_ch.data_byte   = '0;
        byte_ch.end_of_data = 1'b0;
        calm                = 1'b0;
        bytes_sent          = 0;
        scoreboard          = new();

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: raw BGRA extremes, pixel count above the limit
        write_reg(CFG_PIXEL_COUNT, 32'h001f_ffff);
        write_reg(CFG_RLE_MODE, 32'd0);
        write_reg(CFG_BPP, 32'(BPP_BGRA));
        repeat (4) send_byte(8'h00, 1'b0);
        repeat (4) send_byte(8'hff, 1'b0);
        // 24-bit pixel, alpha forced opaque
        wait_for_results();
        write_reg(CFG_BPP, 32'd3);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(8'h56, 1'b0);
        // pixel size shrinks mid-pixel: next byte ends the pixel
        wait_for_results();
        write_reg(CFG_BPP, 32'(BPP_BGRA));
        send_byte(8'ha5, 1'b0);
        send_byte(8'h5a, 1'b0);
        send_byte(8'hc3, 1'b0);
        wait_for_results();
        write_reg(CFG_BPP, 32'd3);
        send_byte(8'h3c, 1'b0);
        // RLE: longest repeat packet, then a one-pixel literal packet
        wait_for_results();
        write_reg(CFG_RLE_MODE, 32'd1);
        write_reg(CFG_BPP, 32'(BPP_BGRA));
        send_byte(8'hff, 1'b0);
        send_random_bytes(4);
        send_byte(8'h00, 1'b0);
        send_random_bytes(4);

        // Random phases, each under its own register settings
        first_random = bytes_sent;
        while (bytes_sent < first_random + RANDOM_ITEMS) begin
            wait_for_results();
            calm = ($urandom_range(0, 4) == 0);
            write_reg(CFG_RLE_MODE, 32'($urandom_range(0, 1)));
            case ($urandom_range(0, 9))
                0:          write_reg(CFG_BPP, 32'($urandom_range(0, 7)));
                1, 2, 3, 4: write_reg(CFG_BPP, 32'd3);
                default:    write_reg(CFG_BPP, 32'(BPP_BGRA));
            endcase
            case ($urandom_range(0, 7))
                0: write_reg(CFG_PIXEL_COUNT, 32'(PIXEL_LIMIT));
                1: write_reg(CFG_PIXEL_COUNT, 32'h001f_ffff);
                2: write_reg(CFG_PIXEL_COUNT, 32'($urandom_range(600000, 2097151)));
                default: ;
            endcase
            nb = scoreboard.pixel_bytes();
            realign();
            if (!scoreboard.rle_on) begin
                send_random_bytes($urandom_range(1, 40) * nb);
            end else begin
                repeat ($urandom_range(1, 8)) begin
                    if ($urandom_range(0, 1) == 1) begin
                        // repeat packet: one pixel for the whole run
                        header = {1'b1, 7'($urandom_range(0, 127))};
                        send_byte(header, 1'b0);
                        send_random_bytes(nb);
                    end else begin
                        low7 = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127)
                                                           : $urandom_range(0, 7);
                        send_byte({1'b0, 7'(low7)}, 1'b0);
                        send_random_bytes((low7 + 1) * nb);
                    end
                end
            end
            // now and then leave a pixel or packet unfinished across the next writes
            if ($urandom_range(0, 3) == 0)
                send_random_bytes($urandom_range(1, 4));
        end

        // Bring the image to an end in one of the ways the core allows
        wait_for_results();
        calm   = 1'b0;
        ending = t_ending'($urandom_range(0, 3));
        case (ending)
            END_SHORT_PIXEL: begin
                // last byte completes a pixel, image still short
                realign();
                if (scoreboard.rle_on) send_byte(rand_byte(), 1'b0);
                nb = scoreboard.pixel_bytes();
                send_random_bytes(nb - 1);
                send_byte(rand_byte(), 1'b1);
            end
            END_MID_PIXEL: begin
                // data ends on a header or inside a pixel: error-only beat
                realign();
                nb = scoreboard.pixel_bytes();
                if (scoreboard.rle_on && $urandom_range(0, 1) == 1) begin
                    send_byte(rand_byte(), 1'b1);
                end else begin
                    if (scoreboard.rle_on) send_byte(rand_byte(), 1'b0);
                    send_random_bytes($urandom_range(0, nb - 2));
                    send_byte(rand_byte(), 1'b1);
                end
            end
            END_IMAGE_DONE: begin
                // image completes exactly on the last byte
                write_reg(CFG_RLE_MODE, 32'd0);
                realign();
                wait_for_results();
                if ($urandom_range(0, 3) == 0) begin
                    need = 1;
                    write_reg(CFG_PIXEL_COUNT, 32'd0);
                end else begin
                    need = $urandom_range(1, 3);
                    write_reg(CFG_PIXEL_COUNT, 32'(scoreboard.done_pixels + need));
                end
                nb = scoreboard.pixel_bytes();
                send_random_bytes(need * nb - 1);
                send_byte(rand_byte(), 1'b1);
            end
            default: begin
                // packet header that runs past the image size
                write_reg(CFG_RLE_MODE, 32'd1);
                realign();
                wait_for_results();
                spare = $urandom_range(0, 60);
                write_reg(CFG_PIXEL_COUNT, 32'(scoreboard.done_pixels + spare));
                header = {1'($urandom_range(0, 1)), 7'($urandom_range(spare, 127))};
                send_byte(header, 1'($urandom_range(0, 1)));
            end
        endcase

        // the core has stopped: these are dropped without a beat
        repeat ($urandom_range(2, 6)) send_byte(rand_byte(), 1'($urandom_range(0, 1)));
        wait_for_results();

        if (scoreboard.mismatches == 0)
            $display("tga_truecolor_rle_decoder_core_tb: done, clean");
        else
            $display("tga_truecolor_rle_decoder_core_tb: done, errors");
        $finish;
    end

endmodule
